### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the generator's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, muted while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication during reset");

`endif

### rtl/core/mtwg_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 word generator package
// Operation codes, field widths, tempering constants and shared types.
// ----------------------------------------------------------------------------
package mtwg_pkg;

  // Field widths of the transaction payloads.
  localparam int OP_W         = 2;
  localparam int WORD_INDEX_W = 10;
  localparam int WORD_W       = 32;

  // Operation codes; code 3 is ignored.
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_RAW    = 2'd1;
  localparam logic [OP_W-1:0] OP_RANGED = 2'd2;

  // Default generator geometry.
  localparam int DEF_STATE_WORDS   = 624;
  localparam int DEF_MIDDLE_OFFSET = 397;

  // Twist and tempering constants.
  localparam logic [WORD_W-1:0] MATRIX_A    = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C    = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] ALL_ONES    = 32'hffff_ffff;

  // Rejection limit of a ranged draw.
  localparam int MAX_TRIES = 1024;
  localparam int TRY_W     = $clog2(MAX_TRIES);

  // Verdict of the draw unit on the current twisted word.
  typedef struct packed {
    logic              take;
    logic [WORD_W-1:0] value;
  } draw_res_t;

endpackage

### rtl/core/mtwg_state_mem.sv
// ----------------------------------------------------------------------------
// MT19937 state memory
// State word store with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtwg_state_mem #(
  parameter int DEPTH  = mtwg_pkg::DEF_STATE_WORDS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [mtwg_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr_a,
  input  logic [ADDR_W-1:0]           raddr_b,
  output logic [mtwg_pkg::WORD_W-1:0] rdata_a,
  output logic [mtwg_pkg::WORD_W-1:0] rdata_b
);
  import mtwg_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/core/mtwg_draw_unit.sv
// ----------------------------------------------------------------------------
// MT19937 draw unit
// Tempers a twisted word and decides whether a draw finishes with it.
// ----------------------------------------------------------------------------
module mtwg_draw_unit (
  input  logic [mtwg_pkg::WORD_W-1:0] word,
  input  logic [mtwg_pkg::WORD_W-1:0] mask,
  input  logic [mtwg_pkg::WORD_W-1:0] range,
  input  logic [mtwg_pkg::WORD_W-1:0] low,
  input  logic                        empty,
  input  logic                        last_try,
  output mtwg_pkg::draw_res_t         res
);
  import mtwg_pkg::*;

  // Standard MT19937 output tempering.
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  logic [WORD_W-1:0] masked;
  logic              hit;

  // Masked word is accepted when it does not exceed the range.
  assign masked = temper(word) & mask;
  assign hit    = (masked <= range);

  // An empty range yields zero; running out of tries yields the low bound.
  always_comb begin
    res.take = empty || hit || last_try;
    priority if (empty) begin
      res.value = '0;
    end else if (hit) begin
      res.value = masked + low;
    end else begin
      res.value = low;
    end
  end

endmodule

### rtl/core/mt19937_word_generator.sv
// A load is written at its acceptance edge. A draw reads the state RAM when
// accepted, writes the twisted word back in ST_TWIST and registers its result
// from ST_TEMPER; an empty range skips the twist, a rejected word repeats it.
// Throughput: one load per cycle, but a draw stalls the input until it retires.
// Reset clears the word pointer and control state; state words hold garbage
// until loaded, and there is no clearing pass.
// ----------------------------------------------------------------------------
// MT19937 word generator
// Incremental MT19937 with state loading, raw draws and ranged draws.
// ----------------------------------------------------------------------------
module mt19937_word_generator #(
  parameter int STATE_WORDS   = mtwg_pkg::DEF_STATE_WORDS,
  parameter int MIDDLE_OFFSET = mtwg_pkg::DEF_MIDDLE_OFFSET
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [mtwg_pkg::OP_W-1:0]                in_operation,
  input  logic [mtwg_pkg::WORD_INDEX_W-1:0]        in_word_index,
  input  logic [mtwg_pkg::WORD_W-1:0]              in_word_value,
  input  logic signed [mtwg_pkg::WORD_W-1:0]       in_range_low,
  input  logic signed [mtwg_pkg::WORD_W-1:0]       in_range_high,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [mtwg_pkg::WORD_W-1:0]       out_value
);
  import mtwg_pkg::*;

  localparam int ADDR_W = $clog2(STATE_WORDS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TWIST  = 2'd1;
  localparam logic [1:0] ST_TEMPER = 2'd2;

  // Smear the highest set bit downward to form the bit-length mask.
  function automatic logic [WORD_W-1:0] smear(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] m;
    m = v | (v >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              upper_r, upper_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] mask_r, mask_nxt;
  logic [WORD_W-1:0] range_r, range_nxt;
  logic [WORD_W-1:0] low_r, low_nxt;
  logic              empty_r, empty_nxt;
  logic [TRY_W-1:0]  tries_r, tries_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;

  logic              in_acc;
  logic              is_load;
  logic              is_draw;
  logic              is_ranged;
  logic              empty_now;
  logic              load_ok;
  logic              slot_free;
  logic              finish;
  logic              retry;
  logic              issue;
  logic [ADDR_W-1:0] next_addr;
  logic [ADDR_W:0]   mid_sum;
  logic [ADDR_W-1:0] mid_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] rd_next;
  logic [WORD_W-1:0] rd_mid;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] twisted;
  logic [WORD_W-1:0] diff;
  draw_res_t         res;

  // Decode the incoming transaction.
  assign is_load   = (in_operation == OP_LOAD);
  assign is_ranged = (in_operation == OP_RANGED);
  assign is_draw   = in_acc && ((in_operation == OP_RAW) || is_ranged);
  assign load_ok   = in_acc && is_load &&
                     ({{(32-WORD_INDEX_W){1'b0}}, in_word_index} < 32'(STATE_WORDS));
  assign empty_now = (in_range_high <= in_range_low);
  assign diff      = in_range_high - in_range_low;

  // Handshake: take a new transaction when idle or as the current draw retires.
  assign slot_free = !out_valid_r || !out_stall;
  assign finish    = (state_r == ST_TEMPER) && res.take && slot_free;
  assign retry     = (state_r == ST_TEMPER) && !res.take;
  assign in_stall  = !((state_r == ST_IDLE) || finish);
  assign in_acc    = in_valid && !in_stall;

  // Neighbor addresses of the word under the pointer.
  assign next_addr = (ptr_r == ADDR_W'(STATE_WORDS - 1)) ? '0 : ptr_r + 1'b1;
  assign mid_sum   = {1'b0, ptr_r} + (ADDR_W + 1)'(MIDDLE_OFFSET);
  assign mid_addr  = (mid_sum >= (ADDR_W + 1)'(STATE_WORDS)) ?
                     ADDR_W'(mid_sum - (ADDR_W + 1)'(STATE_WORDS)) : mid_sum[ADDR_W-1:0];

  // Read issue for a new draw or a rejected ranged word.
  assign issue = is_draw || retry;

  // The state machine keeps reads and the write-back of one word apart,
  // so no access to one entry overlaps another.
  assign mem_we    = load_ok || (state_r == ST_TWIST);
  assign mem_waddr = (state_r == ST_TWIST) ? ptr_r : in_word_index[ADDR_W-1:0];
  assign mem_wdata = (state_r == ST_TWIST) ? twisted : in_word_value;

  mtwg_state_mem #(
    .DEPTH  (STATE_WORDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (issue),
    .raddr_a (next_addr),
    .raddr_b (mid_addr),
    .rdata_a (rd_next),
    .rdata_b (rd_mid)
  );

  // Twist: upper bit of the current word comes from the cached copy.
  assign y       = {upper_r, rd_next[WORD_W-2:0]};
  assign twisted = rd_mid ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);

  mtwg_draw_unit u_draw (
    .word     (word_r),
    .mask     (mask_r),
    .range    (range_r),
    .low      (low_r),
    .empty    (empty_r),
    .last_try (tries_r == TRY_W'(MAX_TRIES - 1)),
    .res      (res)
  );

  // Control and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    upper_nxt     = upper_r;
    word_nxt      = word_r;
    mask_nxt      = mask_r;
    range_nxt     = range_r;
    low_nxt       = low_r;
    empty_nxt     = empty_r;
    tries_nxt     = tries_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    // Output register drains when the consumer takes the transaction.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res.value;
      state_nxt     = ST_IDLE;
    end

    // Keep the cached upper bit in step with a load to the current word.
    if (load_ok && (in_word_index == WORD_INDEX_W'(ptr_r))) begin
      upper_nxt = in_word_value[WORD_W-1];
    end

    // A new draw captures its range parameters.
    if (is_draw) begin
      tries_nxt = '0;
      if (is_ranged) begin
        empty_nxt = empty_now;
        range_nxt = diff;
        mask_nxt  = smear(diff);
        low_nxt   = in_range_low;
        state_nxt = empty_now ? ST_TEMPER : ST_TWIST;
      end else begin
        empty_nxt = 1'b0;
        range_nxt = ALL_ONES;
        mask_nxt  = ALL_ONES;
        low_nxt   = '0;
        state_nxt = ST_TWIST;
      end
    end

    // Write-back cycle advances the pointer.
    if (state_r == ST_TWIST) begin
      word_nxt  = twisted;
      ptr_nxt   = next_addr;
      upper_nxt = rd_next[WORD_W-1];
      state_nxt = ST_TEMPER;
    end

    // A rejected word starts another twist.
    if (retry) begin
      tries_nxt = tries_r + 1'b1;
      state_nxt = ST_TWIST;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    upper_r     <= upper_nxt;
    word_r      <= word_nxt;
    mask_r      <= mask_nxt;
    range_r     <= range_nxt;
    low_r       <= low_nxt;
    empty_r     <= empty_nxt;
    tries_r     <= tries_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

### rtl/core/mtwg_checker.sv
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// MT19937 word generator checker
// Port-level assertions on timing and handshake behavior of the generator.
// ----------------------------------------------------------------------------
module mtwg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [mtwg_pkg::OP_W-1:0]           in_operation,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [mtwg_pkg::WORD_W-1:0]  out_value
);
  import mtwg_pkg::*;

  logic raw_acc;

  assign raw_acc = in_valid && !in_stall && (in_operation == OP_RAW);

  // No result is pending right after reset.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // A stalled result transaction holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value))

  // A raw draw is busy with its write-back in the following cycle.
  `ASSERT_NEXT(a_raw_busy, clk, rst_n, raw_acc, in_stall)

  // With an empty output, a raw draw delivers its word after its twist and temper states.
  `ASSERT_IMPLY(a_raw_latency, clk, rst_n, raw_acc && !out_valid, ##3 out_valid)

endmodule

bind mt19937_word_generator mtwg_checker u_mtwg_checker (.*);

### tb/mt19937_word_generator_tb.sv
// ----------------------------------------------------------------------------
// MT19937 word generator testbench
// Loads the full state, then runs directed and random load, raw-draw and
// ranged-draw transactions under varying back-pressure. Every accepted
// request is run through a behavioral twist-and-temper predictor, and each
// result is compared against the oldest predicted word.
// ----------------------------------------------------------------------------
module mt19937_word_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtwg_pkg::*;

  localparam int STATE_WORDS   = DEF_STATE_WORDS;
  localparam int MIDDLE_OFFSET = DEF_MIDDLE_OFFSET;
  localparam int RANDOM_ITEMS  = 390;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 16;

  // Operation code 3 is not used by the block and must be ignored.
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] TOP_BIT   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] INT_MIN   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] INT_MAX   = 32'h7fff_ffff;

  // Idling profiles: sender light and receiver heavy, then swapped, then none.
  localparam int PH_SEND_LIGHT = 0;
  localparam int PH_SEND_HEAVY = 1;
  localparam int PH_NO_IDLE    = 2;

  typedef struct {
    logic [OP_W-1:0]                operation;
    logic [WORD_INDEX_W-1:0]        word_index;
    logic [WORD_W-1:0]              word_value;
    logic signed [WORD_W-1:0]       range_low;
    logic signed [WORD_W-1:0]       range_high;
    int                             phase;
    bit                             hold_here;
  } gen_request_t;

  logic                             clk;
  logic                             rst_n         = 1'b0;
  logic                             in_valid      = 1'b0;
  logic                             in_stall;
  logic [OP_W-1:0]                  in_operation  = '0;
  logic [WORD_INDEX_W-1:0]          in_word_index = '0;
  logic [WORD_W-1:0]                in_word_value = '0;
  logic signed [WORD_W-1:0]         in_range_low  = '0;
  logic signed [WORD_W-1:0]         in_range_high = '0;
  logic                             out_valid;
  logic                             out_stall     = 1'b0;
  logic signed [WORD_W-1:0]         out_value;

  // Predictor state: a private copy of the state words and the word pointer.
  logic [WORD_W-1:0]                mt_words [STATE_WORDS];
  int unsigned                      word_ptr = 0;

  gen_request_t                     pending_requests [$];
  gen_request_t                     active_request;
  logic signed [WORD_W-1:0]         predicted_words [$];

  int                               idle_phase    = PH_NO_IDLE;
  bit                               hold_request  = 1'b0;
  bit                               hold_done     = 1'b0;
  int                               hold_left     = 0;

  int unsigned                      error_count     = 0;
  int unsigned                      results_checked = 0;
  int unsigned                      loads_applied   = 0;
  int unsigned                      ignored_items   = 0;
  int unsigned                      raw_draws       = 0;
  int unsigned                      ranged_draws    = 0;
  int unsigned                      empty_ranges    = 0;
  int unsigned                      rejected_words  = 0;

  mt19937_word_generator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_word_index (in_word_index),
    .in_word_value (in_word_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int sender_idle_pct(int phase);
    case (phase)
      PH_SEND_LIGHT: return 12;
      PH_SEND_HEAVY: return 58;
      default:       return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(int phase);
    case (phase)
      PH_SEND_LIGHT: return 58;
      PH_SEND_HEAVY: return 12;
      default:       return 0;
    endcase
  endfunction

  // Twist the word at the pointer, write it back, advance and temper it.
  function automatic logic [WORD_W-1:0] twist_and_temper();
    int unsigned       nxt;
    int unsigned       mid;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] w;
    nxt = (word_ptr + 1) % STATE_WORDS;
    mid = (word_ptr + MIDDLE_OFFSET) % STATE_WORDS;
    y = (mt_words[word_ptr] & TOP_BIT) | (mt_words[nxt] & ~TOP_BIT);
    w = mt_words[mid] ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
    mt_words[word_ptr] = w;
    word_ptr = nxt;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

  // Apply one accepted request to the predictor and queue its result, if any.
  function automatic void predict_request(gen_request_t req);
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] low_bits;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] t;
    int unsigned       bits;
    bit                found;
    case (req.operation)
      OP_LOAD: begin
        if (req.word_index < STATE_WORDS) begin
          mt_words[req.word_index] = req.word_value;
          loads_applied++;
        end else begin
          ignored_items++;
        end
      end
      OP_RAW: begin
        predicted_words.push_back(twist_and_temper());
        raw_draws++;
      end
      OP_RANGED: begin
        ranged_draws++;
        if (req.range_high <= req.range_low) begin
          // Empty range: zero, and the state is left alone.
          predicted_words.push_back('0);
          empty_ranges++;
        end else begin
          low_bits = req.range_low;
          span = req.range_high - req.range_low;
          bits = 0;
          for (t = span; t != 0; t = t >> 1) bits++;
          mask = ALL_ONES >> (WORD_W - bits);
          found = 1'b0;
          r = '0;
          for (int tries = 0; tries < MAX_TRIES && !found; tries++) begin
            r = twist_and_temper() & mask;
            if (r <= span) found = 1'b1;
            else rejected_words++;
          end
          // After too many rejections the block gives the low bound.
          predicted_words.push_back(found ? r + low_bits : low_bits);
        end
      end
      default: begin
        ignored_items++;
      end
    endcase
  endfunction

  // A request with random contents in every payload field.
  function automatic gen_request_t random_request(logic [OP_W-1:0] op, int phase);
    gen_request_t req;
    req.operation  = op;
    req.word_index = WORD_INDEX_W'($urandom_range(0, 1023));
    req.word_value = $urandom;
    req.range_low  = $urandom;
    req.range_high = $urandom;
    req.phase      = phase;
    req.hold_here  = 1'b0;
    return req;
  endfunction

  function automatic gen_request_t load_request(int unsigned idx, logic [WORD_W-1:0] val,
                                                int phase);
    gen_request_t req;
    req = random_request(OP_LOAD, phase);
    req.word_index = WORD_INDEX_W'(idx);
    req.word_value = val;
    return req;
  endfunction

  function automatic gen_request_t ranged_request(logic [WORD_W-1:0] lo,
                                                  logic [WORD_W-1:0] hi, int phase);
    gen_request_t req;
    req = random_request(OP_RANGED, phase);
    req.range_low  = lo;
    req.range_high = hi;
    return req;
  endfunction

  // Ranged draw bounds of a random shape: narrow, wide, power-of-two span or one
  // less, empty, or built from the signed extremes and values near zero.
  function automatic gen_request_t random_ranged(int phase);
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    int unsigned       k;
    lo = $urandom;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: hi = lo + $urandom_range(1, 20);
      1: hi = $urandom;
      2: hi = lo + (32'd1 << k);
      3: hi = lo + (32'd1 << k) - 1;
      4: hi = lo - $urandom_range(0, 5);
      default: begin
        case ($urandom_range(0, 2))
          0: lo = INT_MIN;
          1: lo = ALL_ONES;
          default: lo = '0;
        endcase
        case ($urandom_range(0, 2))
          0: hi = INT_MAX;
          1: hi = '0;
          default: hi = 32'd1;
        endcase
      end
    endcase
    return ranged_request(lo, hi, phase);
  endfunction

  // Driver: offers pending requests, holding each one until it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(active_request);
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(pending_requests[0].phase)) begin
          active_request = pending_requests.pop_front();
          in_operation  <= active_request.operation;
          in_word_index <= active_request.word_index;
          in_word_value <= active_request.word_value;
          in_range_low  <= active_request.range_low;
          in_range_high <= active_request.range_high;
          in_valid      <= 1'b1;
          idle_phase    <= active_request.phase;
          if (active_request.hold_here) hold_request <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random back-pressure plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct(idle_phase));
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_words.size() == 0) begin
        $error("unexpected result transaction: value %0d", out_value);
        error_count++;
      end else begin
        logic signed [WORD_W-1:0] want;
        want = predicted_words.pop_front();
        results_checked++;
        if (out_value !== want) begin
          $error("value mismatch: expected %0d, actual %0d", want, out_value);
          error_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    gen_request_t req;
    int unsigned  counted;
    int           phase;
    int unsigned  pick;
    bit           hold_marked;

    // Full state load first, with some ignored transactions mixed in.
    for (int i = 0; i < STATE_WORDS; i++) begin
      pending_requests.push_back(load_request(i, $urandom, PH_SEND_LIGHT));
      if (i % 100 == 50) begin
        pending_requests.push_back(load_request($urandom_range(STATE_WORDS, 1023),
                                                $urandom, PH_SEND_LIGHT));
        pending_requests.push_back(random_request(OP_UNUSED, PH_SEND_LIGHT));
      end
    end

    // Directed part: range extremes, empty ranges, boundary loads, ignored codes.
    pending_requests.push_back(random_request(OP_RAW, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request('0, '0, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(32'd5, -32'sd5, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(INT_MIN, INT_MAX, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(INT_MIN, '0, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(32'd5, 32'd6, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(ALL_ONES, '0, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(INT_MAX - 1, INT_MAX, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(INT_MIN, INT_MIN + 1, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request('0, INT_MAX, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(INT_MAX, INT_MIN, PH_SEND_LIGHT));
    pending_requests.push_back(load_request(0, ALL_ONES, PH_SEND_LIGHT));
    pending_requests.push_back(load_request(1, ALL_ONES, PH_SEND_LIGHT));
    pending_requests.push_back(load_request(STATE_WORDS - 1, '0, PH_SEND_LIGHT));
    pending_requests.push_back(load_request(STATE_WORDS, 32'h1234_5678, PH_SEND_LIGHT));
    pending_requests.push_back(load_request(1023, ALL_ONES, PH_SEND_LIGHT));
    req = random_request(OP_UNUSED, PH_SEND_LIGHT);
    req.word_index = '1;
    req.word_value = ALL_ONES;
    req.range_low  = '1;
    req.range_high = '1;
    pending_requests.push_back(req);
    pending_requests.push_back(random_request(OP_RAW, PH_SEND_LIGHT));
    pending_requests.push_back(random_request(OP_RAW, PH_SEND_LIGHT));
    pending_requests.push_back(ranged_request(-32'sd10, 32'sd10, PH_SEND_LIGHT));
    pending_requests.push_back(random_request(OP_RAW, PH_SEND_LIGHT));

    // Random part, split over the three idling profiles. Ignored
    // transactions are mixed in but not counted.
    counted = 0;
    hold_marked = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      phase = (counted * 3) / RANDOM_ITEMS;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        req = random_request(OP_RAW, phase);
        counted++;
      end else if (pick < 70) begin
        req = random_ranged(phase);
        counted++;
      end else if (pick < 88) begin
        req = load_request($urandom_range(0, STATE_WORDS - 1), $urandom, phase);
        counted++;
      end else if (pick < 94) begin
        req = load_request($urandom_range(STATE_WORDS, 1023), $urandom, phase);
      end else begin
        req = random_request(OP_UNUSED, phase);
      end
      if (!hold_marked && counted >= (2 * RANDOM_ITEMS) / 3 + 40) begin
        req.hold_here = 1'b1;
        hold_marked = 1'b1;
      end
      pending_requests.push_back(req);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d state loads, %0d raw draws and %0d ranged draws (%0d empty).",
             loads_applied, raw_draws, ranged_draws, empty_ranges);
    $display("Checked %0d results; %0d rejected words; %0d ignored transactions.",
             results_checked, rejected_words, ignored_items);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(3_000_000);
    $error("timeout: %0d results still predicted", predicted_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mtwg_pkg.sv
rtl/core/mtwg_state_mem.sv
rtl/core/mtwg_draw_unit.sv
rtl/core/mt19937_word_generator.sv
rtl/core/mtwg_checker.sv
tb/mt19937_word_generator_tb.sv
